@@ rtl/rbb_pkg.sv @@
// ----------------------------------------------------------------------------
// rbb_pkg: shared types and constants of the RGBA 3x3 box blur
// Register indexes, field widths, the classification record passed from the
// front end to the back end, and the reciprocal table used for the averages.
// ----------------------------------------------------------------------------
package rbb_pkg;

	localparam int MAX_WIDTH_DEF = 1024;

	localparam int CH_W   = 8;
	localparam int NUM_CH = 4;
	localparam int PIX_W  = CH_W * NUM_CH;

	localparam int WIDTH_REG_W  = 11;
	localparam int HEIGHT_REG_W = 16;
	localparam int CFG_INDEX_W  = 8;
	localparam int CFG_DATA_W   = 16;

	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_WIDTH  = CFG_INDEX_W'(0);
	localparam logic [CFG_INDEX_W-1:0] REG_IMAGE_HEIGHT = CFG_INDEX_W'(1);

	localparam logic [WIDTH_REG_W-1:0]  WIDTH_RESET  = WIDTH_REG_W'(640);
	localparam logic [HEIGHT_REG_W-1:0] HEIGHT_RESET = HEIGHT_REG_W'(480);

	localparam logic FUNC_PIXEL = 1'b0;
	localparam logic FUNC_FLUSH = 1'b1;

	localparam int QUEUE_DEPTH = 4;

	localparam int SUM_W       = 12;
	localparam int CNT_W       = 4;
	localparam int RECIP_W     = 17;
	localparam int RECIP_SHIFT = 16;
	localparam int PROD_W      = SUM_W + RECIP_W;

	typedef struct packed {
		logic emit;
		logic top_ok;
		logic bot_ok;
		logic left_ok;
		logic right_ok;
		logic frame_end;
	} ctl_t;

	// Rounded-up reciprocals scaled by 2^16; exact for every sum below 2^15.
	function automatic logic [RECIP_W-1:0] recip(input logic [CNT_W-1:0] cnt);
		logic [RECIP_W-1:0] r;
		case (cnt)
			CNT_W'(1): r = RECIP_W'(65536);
			CNT_W'(2): r = RECIP_W'(32768);
			CNT_W'(3): r = RECIP_W'(21846);
			CNT_W'(4): r = RECIP_W'(16384);
			CNT_W'(6): r = RECIP_W'(10923);
			CNT_W'(9): r = RECIP_W'(7282);
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

@@ rtl/rbb_front.sv @@
// ----------------------------------------------------------------------------
// rbb_front: input acceptance and classification
// Holds the frame registers and the input and output position counters, and
// tags every accepted item with its line-store column and border flags.
// ----------------------------------------------------------------------------
module rbb_front import rbb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,
	input  logic                   s_tuser,
	input  logic                   q_full,
	output logic                   q_push,
	output logic [$clog2(MAX_WIDTH)-1:0] q_col,
	output logic [PIX_W-1:0]       q_pix,
	output ctl_t                   q_ctl
);

	localparam int COL_W = $clog2(MAX_WIDTH);
	localparam int EW    = (COL_W + 1 > WIDTH_REG_W) ? COL_W + 1 : WIDTH_REG_W;

	localparam logic [1:0] PHASE_ROW0 = 2'd0;
	localparam logic [1:0] PHASE_ROW1 = 2'd1;
	localparam logic [1:0] PHASE_ROWS = 2'd2;

	logic [WIDTH_REG_W-1:0]  width_q;
	logic [HEIGHT_REG_W-1:0] height_q;
	logic [COL_W-1:0]        in_col_q;
	logic [1:0]              in_phase_q;
	logic [COL_W-1:0]        out_col_q;
	logic [HEIGHT_REG_W-1:0] out_row_q;

	logic [EW-1:0]           w_ext;
	logic [EW-1:0]           w_eff;
	logic [EW-1:0]           w_last;
	logic [HEIGHT_REG_W-1:0] h_last;
	logic                    in_last_col;
	logic                    out_last_col;
	logic                    out_last_row;
	logic                    accept;

	assign w_ext = EW'(width_q);

	always_comb begin
		if (width_q == '0) begin
			w_eff = EW'(1);
		end else if (w_ext > EW'(MAX_WIDTH)) begin
			w_eff = EW'(MAX_WIDTH);
		end else begin
			w_eff = w_ext;
		end
	end

	assign w_last       = w_eff - EW'(1);
	assign h_last       = (height_q == '0) ? '0 : height_q - HEIGHT_REG_W'(1);
	assign in_last_col  = EW'(in_col_q) >= w_last;
	assign out_last_col = EW'(out_col_q) >= w_last;
	assign out_last_row = out_row_q >= h_last;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full;
	assign accept    = s_tvalid && s_tready;
	assign q_push    = accept;
	assign q_col     = in_col_q;
	assign q_pix     = (s_tuser == FUNC_FLUSH) ? '0 : s_tdata;

	always_comb begin
		q_ctl.emit      = (in_phase_q == PHASE_ROWS) ||
		                  (in_phase_q == PHASE_ROW1 && in_col_q != '0);
		q_ctl.top_ok    = out_row_q != '0;
		q_ctl.bot_ok    = !out_last_row;
		q_ctl.left_ok   = out_col_q != '0;
		q_ctl.right_ok  = !out_last_col;
		q_ctl.frame_end = out_last_row && out_last_col;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q    <= WIDTH_RESET;
			height_q   <= HEIGHT_RESET;
			in_col_q   <= '0;
			in_phase_q <= PHASE_ROW0;
			out_col_q  <= '0;
			out_row_q  <= '0;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_IMAGE_WIDTH: begin
					width_q    <= cfg_data[WIDTH_REG_W-1:0];
					in_col_q   <= '0;
					in_phase_q <= PHASE_ROW0;
					out_col_q  <= '0;
					out_row_q  <= '0;
				end
				REG_IMAGE_HEIGHT: begin
					height_q   <= cfg_data[HEIGHT_REG_W-1:0];
					in_col_q   <= '0;
					in_phase_q <= PHASE_ROW0;
					out_col_q  <= '0;
					out_row_q  <= '0;
				end
				default: begin
				end
			endcase
		end else if (accept) begin
			if (q_ctl.emit && q_ctl.frame_end) begin
				in_col_q   <= '0;
				in_phase_q <= PHASE_ROW0;
				out_col_q  <= '0;
				out_row_q  <= '0;
			end else begin
				if (in_last_col) begin
					in_col_q <= '0;
					if (in_phase_q != PHASE_ROWS) begin
						in_phase_q <= in_phase_q + 2'd1;
					end
				end else begin
					in_col_q <= in_col_q + COL_W'(1);
				end
				if (q_ctl.emit) begin
					if (out_last_col) begin
						out_col_q <= '0;
						out_row_q <= out_row_q + HEIGHT_REG_W'(1);
					end else begin
						out_col_q <= out_col_q + COL_W'(1);
					end
				end
			end
		end
	end

endmodule

@@ rtl/rbb_fifo.sv @@
// ----------------------------------------------------------------------------
// rbb_fifo: short queue between the front end and the back end
// A register-based first-in first-out buffer with a combinational read port.
// ----------------------------------------------------------------------------
module rbb_fifo import rbb_pkg::*; #(
	parameter int DATA_W = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic [DATA_W-1:0] push_data,
	output logic              full,
	input  logic              pop,
	output logic [DATA_W-1:0] pop_data,
	output logic              empty
);

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W_Q = $clog2(QUEUE_DEPTH + 1);

	logic [DATA_W-1:0]  mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W_Q-1:0] count_q;
	logic               do_push;
	logic               do_pop;

	assign full     = count_q == CNT_W_Q'(QUEUE_DEPTH);
	assign empty    = count_q == '0;
	assign do_push  = push && !full;
	assign do_pop   = pop && !empty;
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W_Q'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W_Q'(1);
			end
		end
	end

endmodule

@@ rtl/rbb_back.sv @@
// ----------------------------------------------------------------------------
// rbb_back: line stores, window and averaging pipeline
// Reads and rewrites both line stores once per item, shifts the 3x3 window,
// sums the in-image neighbours and divides by their count through a
// reciprocal multiply. The whole pipeline advances when the output register
// can take a new result.
// ----------------------------------------------------------------------------
module rbb_back import rbb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         q_empty,
	output logic                         q_pop,
	input  logic [$clog2(MAX_WIDTH)-1:0] q_col,
	input  logic [PIX_W-1:0]             q_pix,
	input  ctl_t                         q_ctl,
	output logic                         m_tvalid,
	input  logic                         m_tready,
	output logic [PIX_W-1:0]             m_tdata,
	output logic                         m_tlast
);

	localparam int COL_W = $clog2(MAX_WIDTH);

	logic [PIX_W-1:0] upper_mem [MAX_WIDTH];
	logic [PIX_W-1:0] middle_mem [MAX_WIDTH];

	logic                           adv;

	logic                           s1_v;
	logic [COL_W-1:0]               col_s1;
	logic [PIX_W-1:0]               pix_s1;
	ctl_t                           ctl_s1;
	logic                           fwd_s1;
	logic [PIX_W-1:0]               rd_upper_s1;
	logic [PIX_W-1:0]               rd_middle_s1;
	logic [PIX_W-1:0]               fwd_mid_q;
	logic [PIX_W-1:0]               fwd_pix_q;
	logic [PIX_W-1:0]               top_eff;
	logic [PIX_W-1:0]               mid_eff;

	logic                           s2_v;
	ctl_t                           ctl_s2;
	logic [PIX_W-1:0]               win_s2 [9];
	logic [2:0]                     row_ok;
	logic [2:0]                     col_ok;
	logic [1:0]                     rows_c;
	logic [1:0]                     cols_c;
	logic [CNT_W-1:0]               cnt_c;
	logic [NUM_CH-1:0][SUM_W-1:0]   sum_c;

	logic                           s3_v;
	logic [NUM_CH-1:0][SUM_W-1:0]   sum_s3;
	logic [RECIP_W-1:0]             recip_s3;
	logic                           last_s3;
	logic [NUM_CH-1:0][PROD_W-1:0]  prod_c;

	logic                           m_valid_q;
	logic [NUM_CH-1:0][CH_W-1:0]    m_data_q;
	logic                           m_last_q;

	assign adv   = !m_valid_q || m_tready;
	assign q_pop = adv && !q_empty;

	// A read issued in the cycle the previous item writes the same column
	// sees the old word, so that item's write data is forwarded.
	assign top_eff = fwd_s1 ? fwd_mid_q : rd_upper_s1;
	assign mid_eff = fwd_s1 ? fwd_pix_q : rd_middle_s1;

	always_ff @(posedge clk) begin
		if (q_pop) begin
			rd_upper_s1  <= upper_mem[q_col];
			rd_middle_s1 <= middle_mem[q_col];
		end
		if (adv && s1_v) begin
			upper_mem[col_s1]  <= mid_eff;
			middle_mem[col_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (adv) begin
			s1_v <= q_pop;
			if (q_pop) begin
				fwd_s1 <= s1_v && (col_s1 == q_col);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			col_s1 <= q_col;
			pix_s1 <= q_pix;
			ctl_s1 <= q_ctl;
		end
		if (adv && s1_v) begin
			fwd_mid_q <= mid_eff;
			fwd_pix_q <= pix_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_v <= 1'b0;
			for (int i = 0; i < 9; i++) begin
				win_s2[i] <= '0;
			end
		end else if (adv) begin
			s2_v <= s1_v;
			if (s1_v) begin
				for (int r = 0; r < 3; r++) begin
					win_s2[r*3]     <= win_s2[r*3 + 1];
					win_s2[r*3 + 1] <= win_s2[r*3 + 2];
				end
				win_s2[2] <= top_eff;
				win_s2[5] <= mid_eff;
				win_s2[8] <= pix_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s1_v) begin
			ctl_s2 <= ctl_s1;
		end
	end

	assign row_ok = {ctl_s2.bot_ok, 1'b1, ctl_s2.top_ok};
	assign col_ok = {ctl_s2.right_ok, 1'b1, ctl_s2.left_ok};
	assign rows_c = 2'd1 + {1'b0, ctl_s2.top_ok} + {1'b0, ctl_s2.bot_ok};
	assign cols_c = 2'd1 + {1'b0, ctl_s2.left_ok} + {1'b0, ctl_s2.right_ok};
	assign cnt_c  = CNT_W'(rows_c) * CNT_W'(cols_c);

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			sum_c[ch] = '0;
			for (int r = 0; r < 3; r++) begin
				for (int c = 0; c < 3; c++) begin
					if (row_ok[r] && col_ok[c]) begin
						sum_c[ch] = sum_c[ch] + SUM_W'(win_s2[r*3 + c][ch*CH_W +: CH_W]);
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s3_v <= 1'b0;
		end else if (adv) begin
			s3_v <= s2_v && ctl_s2.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s2_v && ctl_s2.emit) begin
			sum_s3   <= sum_c;
			recip_s3 <= recip(cnt_c);
			last_s3  <= ctl_s2.frame_end;
		end
	end

	always_comb begin
		for (int ch = 0; ch < NUM_CH; ch++) begin
			prod_c[ch] = PROD_W'(sum_s3[ch]) * PROD_W'(recip_s3);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (adv) begin
			m_valid_q <= s3_v;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && s3_v) begin
			for (int ch = 0; ch < NUM_CH; ch++) begin
				m_data_q[ch] <= prod_c[ch][RECIP_SHIFT +: CH_W];
			end
			m_last_q <= last_s3;
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;
	assign m_tlast  = m_last_q;

endmodule

@@ rtl/rgba_box_blur_3x3.sv @@
// ----------------------------------------------------------------------------
// rgba_box_blur_3x3: streaming 3x3 box blur of an RGBA raster
// Top level joining the front end, the item queue and the averaging back end.
// ----------------------------------------------------------------------------
// Pixels enter in raster order, one per transfer, and the block sustains one
// item per clock: every item makes a single read and a single write of each
// line store, and the pipeline behind the four-entry queue moves one item per
// cycle whenever the output register is free. A result passes through the
// queue and the read, window, sum and output registers, and in stream
// position it lags its pixel by one row plus one pixel, so after the last
// pixel of a frame the source sends width+1 flush items (tuser set) to drain
// it; tlast marks the final result of the frame. The line stores need no
// clearing pass after reset. Writing either frame register restarts the frame
// and must be done only while the block is idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module rgba_box_blur_3x3 import rbb_pkg::*; #(
	parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [CFG_DATA_W-1:0]  cfg_data,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [PIX_W-1:0]       s_tdata,  // in_red, in_green, in_blue, in_alpha
	input  logic                   s_tuser,  // func
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [PIX_W-1:0]       m_tdata,  // out_red, out_green, out_blue, out_alpha
	output logic                   m_tlast
);

	localparam int COL_W   = $clog2(MAX_WIDTH);
	localparam int ENTRY_W = COL_W + PIX_W + $bits(ctl_t);

	logic               q_full;
	logic               q_empty;
	logic               q_push;
	logic               q_pop;
	logic [COL_W-1:0]   front_col;
	logic [PIX_W-1:0]   front_pix;
	ctl_t               front_ctl;
	logic [COL_W-1:0]   back_col;
	logic [PIX_W-1:0]   back_pix;
	ctl_t               back_ctl;
	logic [ENTRY_W-1:0] push_entry;
	logic [ENTRY_W-1:0] pop_entry;

	assign push_entry = {front_col, front_pix, front_ctl};
	assign {back_col, back_pix, back_ctl} = pop_entry;

	rbb_front #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.q_full    (q_full),
		.q_push    (q_push),
		.q_col     (front_col),
		.q_pix     (front_pix),
		.q_ctl     (front_ctl)
	);

	rbb_fifo #(
		.DATA_W (ENTRY_W)
	) u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (push_entry),
		.full      (q_full),
		.pop       (q_pop),
		.pop_data  (pop_entry),
		.empty     (q_empty)
	);

	rbb_back #(
		.MAX_WIDTH (MAX_WIDTH)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (q_empty),
		.q_pop    (q_pop),
		.q_col    (back_col),
		.q_pix    (back_pix),
		.q_ctl    (back_ctl),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

endmodule

@@ rtl/rbb_checker.sv @@
// ----------------------------------------------------------------------------
// rbb_checker: port-level checks of the RGBA 3x3 box blur
// Watches the top-level ports and is bound to every instance of the block.
// ----------------------------------------------------------------------------
module rbb_checker import rbb_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   cfg_valid,
	input logic                   cfg_ready,
	input logic                   s_tready,
	input logic                   m_tvalid,
	input logic                   m_tready,
	input logic [PIX_W-1:0]       m_tdata,
	input logic                   m_tlast
);

	// A stalled result stays offered.
	a_out_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result withdrawn while stalled");

	// A stalled result keeps its contents.
	a_out_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast))
		else $error("result changed while stalled");

	// Configuration writes are always taken.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("configuration transfer refused");

	// The input side only stalls when the queue has filled behind a stalled result.
	a_in_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> $past(m_tvalid && !m_tready))
		else $error("input stalled without output back-pressure");

endmodule

bind rgba_box_blur_3x3 rbb_checker u_rbb_checker (.*);

@@ test/tb_rgba_box_blur_3x3.sv @@
// ----------------------------------------------------------------------------
// tb_rgba_box_blur_3x3: self-checking testbench of the RGBA 3x3 box blur
// A scoreboard keeps its own line stores, window and frame positions, works
// out the blurred pixel for every transfer that completes a window and compares each result
// channel and the frame marker with it. Directed frames cover the extremes,
// the out-of-range sizes and the odd item kinds, then random frames of small
// sizes run with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_rgba_box_blur_3x3;
	import rbb_pkg::*;

	localparam int CYCLE_LIMIT   = 1000000;
	localparam int SETTLE_CYCLES = 16;
	localparam int RANDOM_ITEMS  = 420;
	localparam int REPORT_LIMIT  = 30;

	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED_TOP = '1;

	typedef struct {
		logic [PIX_W-1:0] pix;
		logic             last;
	} blurred_t;

	class box_blur_scoreboard;
		logic [WIDTH_REG_W-1:0]  width_reg;
		logic [HEIGHT_REG_W-1:0] height_reg;
		logic [PIX_W-1:0]        upper_row [MAX_WIDTH_DEF];
		logic [PIX_W-1:0]        middle_row [MAX_WIDTH_DEF];
		logic [PIX_W-1:0]        win [9];
		int unsigned             in_col, in_row, out_col, out_row;
		blurred_t                blurred_q [$];
		int unsigned             mismatches;

		function new();
			width_reg = WIDTH_RESET;
			height_reg = HEIGHT_RESET;
			foreach (upper_row[i]) begin
				upper_row[i] = '0;
				middle_row[i] = '0;
			end
			foreach (win[i])
				win[i] = '0;
			mismatches = 0;
			restart();
		endfunction

		function void restart();
			in_col = 0;
			in_row = 0;
			out_col = 0;
			out_row = 0;
		endfunction

		function int unsigned frame_w();
			if (width_reg == 0)
				return 1;
			if (width_reg > MAX_WIDTH_DEF)
				return MAX_WIDTH_DEF;
			return width_reg;
		endfunction

		function int unsigned frame_h();
			return (height_reg == 0) ? 1 : height_reg;
		endfunction

		function int unsigned pending();
			return blurred_q.size();
		endfunction

		function void note_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
			if (idx == REG_IMAGE_WIDTH) begin
				width_reg = data[WIDTH_REG_W-1:0];
				restart();
			end else if (idx == REG_IMAGE_HEIGHT) begin
				height_reg = data[HEIGHT_REG_W-1:0];
				restart();
			end
		endfunction

		function void take_item(logic func, logic [PIX_W-1:0] data);
			int unsigned      w, h, col, cnt;
			int unsigned      sum [NUM_CH];
			int               dy, dx, ch;
			logic [PIX_W-1:0] pix, top, mid, p;
			bit               emit;
			blurred_t         res;
			w = frame_w();
			h = frame_h();
			pix = (func == FUNC_PIXEL) ? data : '0;
			col = in_col % MAX_WIDTH_DEF;
			top = upper_row[col];
			mid = middle_row[col];
			upper_row[col] = mid;
			middle_row[col] = pix;
			for (dy = 0; dy < 3; dy++) begin
				win[dy * 3] = win[dy * 3 + 1];
				win[dy * 3 + 1] = win[dy * 3 + 2];
			end
			win[2] = top;
			win[5] = mid;
			win[8] = pix;
			emit = (in_row >= 2) || (in_row == 1 && in_col >= 1);
			in_col++;
			if (in_col >= w) begin
				in_col = 0;
				in_row++;
			end
			if (!emit)
				return;

			for (ch = 0; ch < NUM_CH; ch++)
				sum[ch] = 0;
			cnt = 0;
			for (dy = -1; dy <= 1; dy++) begin
				if (dy < 0 && out_row == 0)
					continue;
				if (dy > 0 && out_row + 1 >= h)
					continue;
				for (dx = -1; dx <= 1; dx++) begin
					if (dx < 0 && out_col == 0)
						continue;
					if (dx > 0 && out_col + 1 >= w)
						continue;
					p = win[(dy + 1) * 3 + dx + 1];
					for (ch = 0; ch < NUM_CH; ch++)
						sum[ch] += p[ch * CH_W +: CH_W];
					cnt++;
				end
			end
			for (ch = 0; ch < NUM_CH; ch++)
				res.pix[ch * CH_W +: CH_W] = CH_W'(sum[ch] / cnt);

			if (out_row + 1 >= h && out_col + 1 >= w) begin
				res.last = 1'b1;
				restart();
			end else begin
				res.last = 1'b0;
				out_col++;
				if (out_col >= w) begin
					out_col = 0;
					out_row++;
				end
			end
			blurred_q.push_back(res);
		endfunction

		function void compare_field(string name, logic [CH_W-1:0] want, logic [CH_W-1:0] got);
			if (got !== want) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$error("%s: expected %0d, got %0d", name, want, got);
			end
		endfunction

		function void check_blurred(logic [PIX_W-1:0] data, logic last);
			blurred_t want;
			if (blurred_q.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT)
					$error("result transfer with no pixel pending: data %h, last %b", data, last);
				return;
			end
			want = blurred_q.pop_front();
			compare_field("out_red", want.pix[0 * CH_W +: CH_W], data[0 * CH_W +: CH_W]);
			compare_field("out_green", want.pix[1 * CH_W +: CH_W], data[1 * CH_W +: CH_W]);
			compare_field("out_blue", want.pix[2 * CH_W +: CH_W], data[2 * CH_W +: CH_W]);
			compare_field("out_alpha", want.pix[3 * CH_W +: CH_W], data[3 * CH_W +: CH_W]);
			compare_field("frame_end", CH_W'(want.last), CH_W'(last));
		endfunction
	endclass

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data = '0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [PIX_W-1:0]       s_tdata = '0;  // in_red, in_green, in_blue, in_alpha
	logic                   s_tuser = 1'b0;  // func
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [PIX_W-1:0]       m_tdata;  // out_red, out_green, out_blue, out_alpha
	logic                   m_tlast;

	box_blur_scoreboard board;
	bit                 steady = 1'b0;
	int unsigned        sent = 0;
	int unsigned        stall_left = 0;
	int unsigned        cycles = 0;

	rgba_box_blur_3x3 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always #2 clk = ~clk;

	function automatic int unsigned idle_len();
		if ($urandom_range(0, 9) != 0)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic int unsigned send_gap();
		if (steady || $urandom_range(0, 99) < 65)
			return 0;
		return idle_len();
	endfunction

	function automatic logic [PIX_W-1:0] random_pixel();
		logic [PIX_W-1:0] p;
		int unsigned      roll, ch;
		roll = $urandom_range(0, 9);
		p = $urandom();
		if (roll == 0)
			p = '0;
		else if (roll == 1)
			p = '1;
		else if (roll == 2)
			for (ch = 0; ch < NUM_CH; ch++)
				p[ch * CH_W +: CH_W] = {CH_W{p[ch]}};
		return p;
	endfunction

	always @(posedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			m_tready <= 1'b0;
		end else if (!steady && $urandom_range(0, 99) < 25) begin
			stall_left <= idle_len() - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			board.check_blurred(m_tdata, m_tlast);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("** rgba_box_blur_3x3: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		board.note_register(idx, data);
	endtask

	task automatic set_frame(logic [CFG_DATA_W-1:0] w, logic [CFG_DATA_W-1:0] h);
		write_reg(REG_IMAGE_WIDTH, w);
		write_reg(REG_IMAGE_HEIGHT, h);
		cfg_valid <= 1'b0;
	endtask

	task automatic send_item(logic func, logic [PIX_W-1:0] data);
		int unsigned gap;
		gap = send_gap();
		s_tvalid <= 1'b1;
		s_tuser <= func;
		s_tdata <= data;
		do @(posedge clk); while (!s_tready);
		board.take_item(func, data);
		sent++;
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(bit may_break, output bit broken);
		int unsigned pixels, total, stop_at, i;
		logic        func;
		pixels = board.frame_w() * board.frame_h();
		total = pixels + board.frame_w() + 1;
		stop_at = total;
		if (may_break && $urandom_range(0, 9) == 0)
			stop_at = $urandom_range(1, total - 1);
		for (i = 0; i < stop_at; i++) begin
			if (i < pixels)
				func = ($urandom_range(0, 19) == 0) ? FUNC_FLUSH : FUNC_PIXEL;
			else
				func = ($urandom_range(0, 9) == 0) ? FUNC_PIXEL : FUNC_FLUSH;
			send_item(func, random_pixel());
		end
		broken = (stop_at != total);
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin
		logic [PIX_W-1:0] demo_pix [9];
		int unsigned      i, roll, w, h, frames, f, random_start;
		bit               broken;
		board = new();
		demo_pix = '{32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h00FF_00FF, 32'h1234_5678,
			32'hFF00_FF00, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0403_0201};
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// A 3x3 frame gives every border count, with an unknown register index
		// written part way through, which must not restart the frame.
		set_frame(3, 3);
		for (i = 0; i < 3; i++)
			send_item(FUNC_PIXEL, demo_pix[i]);
		settle();
		write_reg(CFG_INDEX_W'($urandom_range(2, 254)), CFG_DATA_W'($urandom()));
		write_reg(REG_UNUSED_TOP, '1);
		cfg_valid <= 1'b0;
		for (i = 3; i < 9; i++)
			send_item((i == 4) ? FUNC_FLUSH : FUNC_PIXEL, demo_pix[i]);
		for (i = 0; i < 4; i++)
			send_item((i == 1) ? FUNC_PIXEL : FUNC_FLUSH, random_pixel());
		settle();

		set_frame(0, 0);
		send_item(FUNC_PIXEL, random_pixel());
		send_item(FUNC_FLUSH, random_pixel());
		send_item(FUNC_FLUSH, random_pixel());
		settle();

		set_frame(2, '1);
		steady = 1'b1;
		for (i = 0; i < 120; i++)
			send_item(FUNC_PIXEL, random_pixel());
		steady = 1'b0;
		settle();

		random_start = sent;
		while (sent - random_start < RANDOM_ITEMS) begin
			roll = $urandom_range(0, 19);
			if (roll == 0)
				w = 0;
			else if (roll <= 2)
				w = 1;
			else if (roll <= 15)
				w = $urandom_range(2, 8);
			else
				w = $urandom_range(9, 40);
			roll = $urandom_range(0, 19);
			if (roll == 0)
				h = 0;
			else if (roll <= 2)
				h = 1;
			else
				h = $urandom_range(2, 6);
			set_frame(CFG_DATA_W'(w), CFG_DATA_W'(h));
			steady = ($urandom_range(0, 4) == 0);
			frames = $urandom_range(1, 3);
			broken = 1'b0;
			for (f = 0; f < frames && !broken; f++)
				send_frame(1'b1, broken);
			settle();
		end
		steady = 1'b0;

		if (board.mismatches == 0)
			$display("** rgba_box_blur_3x3: PASSED **");
		else
			$display("** rgba_box_blur_3x3: FAILED **");
		$finish;
	end

endmodule

@@ rgba_box_blur_3x3.f @@
rtl/rbb_pkg.sv
rtl/rbb_front.sv
rtl/rbb_fifo.sv
rtl/rbb_back.sv
rtl/rgba_box_blur_3x3.sv
rtl/rbb_checker.sv
test/tb_rgba_box_blur_3x3.sv
